### hw/rtl/acrr_pkg.sv
// Shared types and constants for the address cache with request retry.
`default_nettype none
package acrr_pkg;

  typedef enum logic [1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_QUEUE  = 2'd2,
    REQ_TICK   = 2'd3
  } req_t;

  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_SEND   = 2'd1;
  localparam logic [1:0] ACT_UNREACH = 2'd2;
  localparam logic [1:0] ACT_FULL   = 2'd3;

  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_RETRY   = 1'b1;

  localparam logic [7:0] AGE_MAX = 8'hFF;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;        // capture request fields, clear scan flags
    logic cache_scan;  // examine cache entry at the cache index
    logic pend_scan;   // examine pending slot at the pending index
    logic insert_wr;   // write pair into the free cache entry found
    logic queue_wr;    // write ip into the free pending slot found
    logic tick_age;    // age cache entry at the cache index
    logic tick_pend;   // update pending slot at the pending index
    logic out_load;    // build a result into the output register
    logic out_last;    // result closes the request
    logic tick_empty;  // result is the single empty tick result
  } acrr_cmd_t;

  typedef struct packed {
    logic pend_more;   // a valid pending slot lies above the index
    logic pend_valid;  // pending slot at index is valid
  } acrr_sts_t;

endpackage
`default_nettype wire

### hw/rtl/acrr_datapath.sv
// Datapath: cache and pending tables, scan registers and result register.
`default_nettype none
module acrr_datapath
  import acrr_pkg::*;
#(
  parameter int CACHE_ENTRIES   = 32,
  parameter int PENDING_ENTRIES = 16,
  parameter int CW = $clog2(CACHE_ENTRIES),
  parameter int PW = $clog2(PENDING_ENTRIES)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire acrr_cmd_t     cmd,
  input  wire logic [CW-1:0] cidx,
  input  wire logic [PW-1:0] pidx,
  input  wire logic [1:0]    req_type,
  input  wire logic [31:0]   ip,
  input  wire logic [47:0]   mac,
  input  wire logic [7:0]    entry_timeout,
  input  wire logic [3:0]    retry_limit,
  output acrr_sts_t          sts,
  output logic               hit,
  output logic [47:0]        mac_out,
  output logic               pending_found,
  output logic [1:0]         action,
  output logic [31:0]        action_ip,
  output logic [3:0]         pending_slot,
  output logic               last
);

  logic [CACHE_ENTRIES-1:0]   entry_valid;
  logic [31:0]                entry_ip  [CACHE_ENTRIES];
  logic [47:0]                entry_mac [CACHE_ENTRIES];
  logic [7:0]                 entry_age [CACHE_ENTRIES];
  logic [PENDING_ENTRIES-1:0] pend_valid;
  logic [31:0]                pend_ip    [PENDING_ENTRIES];
  logic [3:0]                 pend_tries [PENDING_ENTRIES];

  logic [1:0]    rtype;
  logic [31:0]   rip;
  logic [47:0]   rmac;
  logic          found;
  logic [47:0]   found_mac;
  logic          cfree;
  logic [CW-1:0] cfree_idx;
  logic          pfree;
  logic [PW-1:0] pfree_idx;
  logic          pmatch;
  logic [PW-1:0] pmatch_idx;

  logic [31:0] c_ip;
  logic [47:0] c_mac;
  logic [7:0]  c_age;
  logic        c_vld;
  logic [31:0] p_ip;
  logic [3:0]  p_tries;
  logic        p_vld;
  logic [7:0]  age_inc;
  logic [PENDING_ENTRIES-1:0] p_above;

  logic        hit_next;
  logic [47:0] mac_next;
  logic        pf_next;
  logic [1:0]  act_next;
  logic [31:0] aip_next;
  logic [3:0]  slot_next;
  logic        last_next;

  assign c_ip    = entry_ip[cidx];
  assign c_mac   = entry_mac[cidx];
  assign c_age   = entry_age[cidx];
  assign c_vld   = entry_valid[cidx];
  assign p_ip    = pend_ip[pidx];
  assign p_tries = pend_tries[pidx];
  assign p_vld   = pend_valid[pidx];
  assign age_inc = (c_age == AGE_MAX) ? c_age : c_age + 8'd1;
  assign p_above = (pend_valid >> pidx) >> 1;

  assign sts.pend_valid = p_vld;
  assign sts.pend_more  = |p_above;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      pend_valid  <= '0;
    end else begin
      if (cmd.load) begin
        rtype  <= req_type;
        rip    <= ip;
        rmac   <= mac;
        found  <= 1'b0;
        found_mac <= '0;
        cfree  <= 1'b0;
        cfree_idx <= '0;
        pfree  <= 1'b0;
        pfree_idx <= '0;
        pmatch <= 1'b0;
        pmatch_idx <= '0;
      end
      if (cmd.cache_scan) begin
        if (c_vld && c_ip == rip) begin
          found     <= 1'b1;
          found_mac <= c_mac;
        end
        if (!c_vld && !cfree) begin
          cfree     <= 1'b1;
          cfree_idx <= cidx;
        end
      end
      if (cmd.pend_scan) begin
        if (p_vld && p_ip == rip && !pmatch) begin
          pmatch     <= 1'b1;
          pmatch_idx <= pidx;
          // insert drops the pending request at once
          if (rtype == REQ_INSERT) pend_valid[pidx] <= 1'b0;
        end
        if (!p_vld && !pfree) begin
          pfree     <= 1'b1;
          pfree_idx <= pidx;
        end
      end
      if (cmd.insert_wr && cfree) begin
        entry_valid[cfree_idx] <= 1'b1;
        entry_ip[cfree_idx]    <= rip;
        entry_mac[cfree_idx]   <= rmac;
        entry_age[cfree_idx]   <= '0;
      end
      if (cmd.queue_wr && !pmatch && pfree) begin
        pend_valid[pfree_idx] <= 1'b1;
        pend_ip[pfree_idx]    <= rip;
        pend_tries[pfree_idx] <= '0;
      end
      if (cmd.tick_age && c_vld) begin
        entry_age[cidx] <= age_inc;
        if (age_inc > entry_timeout) entry_valid[cidx] <= 1'b0;
      end
      if (cmd.tick_pend && p_vld) begin
        if (p_tries >= retry_limit) pend_valid[pidx] <= 1'b0;
        else pend_tries[pidx] <= p_tries + 4'd1;
      end
    end
  end

  always_comb begin
    hit_next  = 1'b0;
    mac_next  = '0;
    pf_next   = 1'b0;
    act_next  = ACT_NONE;
    aip_next  = rip;
    slot_next = '0;
    last_next = cmd.out_last;
    if (cmd.tick_empty) begin
      aip_next = '0;
    end else if (cmd.tick_pend) begin
      act_next  = (p_tries >= retry_limit) ? ACT_UNREACH : ACT_SEND;
      aip_next  = p_ip;
      slot_next = 4'(pidx);
    end else begin
      unique case (rtype)
        REQ_LOOKUP: begin
          hit_next = found;
          mac_next = found_mac;
        end
        REQ_INSERT: begin
          pf_next   = pmatch;
          slot_next = pmatch ? 4'(pmatch_idx) : 4'd0;
          act_next  = cfree ? ACT_NONE : ACT_FULL;
        end
        REQ_QUEUE: begin
          if (pmatch) slot_next = 4'(pmatch_idx);
          else if (pfree) slot_next = 4'(pfree_idx);
          else act_next = ACT_FULL;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      hit           <= hit_next;
      mac_out       <= mac_next;
      pending_found <= pf_next;
      action        <= act_next;
      action_ip     <= aip_next;
      pending_slot  <= slot_next;
      last          <= last_next;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/acrr_ctrl.sv
// Controller: sequences scans, writes and result hand-off per request.
`default_nettype none
module acrr_ctrl
  import acrr_pkg::*;
#(
  parameter int CACHE_ENTRIES   = 32,
  parameter int PENDING_ENTRIES = 16,
  parameter int CW = $clog2(CACHE_ENTRIES),
  parameter int PW = $clog2(PENDING_ENTRIES)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic [1:0]    req_type,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  input  wire acrr_sts_t     sts,
  output acrr_cmd_t          cmd,
  output logic [CW-1:0]      cidx,
  output logic [PW-1:0]      pidx
);

  typedef enum logic [2:0] {
    S_IDLE, S_CSCAN, S_PSCAN, S_WRITE, S_AGE, S_TPEND, S_EMIT
  } state_t;

  state_t state;
  logic [1:0] rtype;
  logic out_free;
  logic c_end;
  logic p_end;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) || !out_free;
  assign c_end = (cidx == CW'(CACHE_ENTRIES - 1));
  assign p_end = (pidx == PW'(PENDING_ENTRIES - 1));

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:  cmd.load = in_valid && out_free;
      S_CSCAN: cmd.cache_scan = 1'b1;
      S_PSCAN: cmd.pend_scan = 1'b1;
      S_WRITE: begin
        cmd.insert_wr = (rtype == REQ_INSERT);
        cmd.queue_wr  = (rtype == REQ_QUEUE);
      end
      S_AGE:   cmd.tick_age = 1'b1;
      S_TPEND: begin
        cmd.tick_pend = out_free;
        cmd.out_load  = out_free && sts.pend_valid;
        cmd.out_last  = !sts.pend_more;
      end
      S_EMIT: begin
        cmd.out_load   = out_free;
        cmd.out_last   = 1'b1;
        cmd.tick_empty = (rtype == REQ_TICK);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cidx      <= '0;
      pidx      <= '0;
      rtype     <= REQ_LOOKUP;
    end else begin
      out_valid <= cmd.out_load || (out_valid && out_stall);
      unique case (state)
        S_IDLE: if (in_valid && out_free) begin
          rtype    <= req_type;
          cidx     <= '0;
          pidx     <= '0;
          unique case (req_type)
            REQ_LOOKUP: state <= S_CSCAN;
            REQ_INSERT: state <= S_CSCAN;
            REQ_QUEUE:  state <= S_PSCAN;
            default:    state <= S_AGE;
          endcase
        end
        S_CSCAN: begin
          cidx <= cidx + CW'(1);
          if (c_end) state <= (rtype == REQ_LOOKUP) ? S_EMIT : S_PSCAN;
        end
        S_PSCAN: begin
          pidx <= pidx + PW'(1);
          if (p_end) state <= S_WRITE;
        end
        S_WRITE: state <= S_EMIT;
        S_AGE: begin
          cidx <= cidx + CW'(1);
          if (c_end) state <= S_TPEND;
        end
        S_TPEND: if (out_free) begin
          pidx <= pidx + PW'(1);
          // finish on the highest valid slot
          if (sts.pend_valid && !sts.pend_more) state <= S_IDLE;
          // no pending request at all: one empty result follows
          else if (p_end) state <= S_EMIT;
        end
        S_EMIT: if (out_free) begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### hw/rtl/acrr_hold.sv
// Output register stage between the result register and the output port.
`default_nettype none
module acrr_hold (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [47:0] i_mac,
  input  wire logic        i_hit,
  input  wire logic        i_pf,
  input  wire logic [1:0]  i_act,
  input  wire logic [31:0] i_ip,
  input  wire logic [3:0]  i_slot,
  input  wire logic        i_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             hit,
  output logic [47:0]      mac_out,
  output logic             pending_found,
  output logic [1:0]       action,
  output logic [31:0]      action_ip,
  output logic [3:0]       pending_slot,
  output logic             last
);

  logic go;

  assign go = !out_valid || !out_stall;
  assign in_stall = !go;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go && in_valid) begin
      hit           <= i_hit;
      mac_out       <= i_mac;
      pending_found <= i_pf;
      action        <= i_act;
      action_ip     <= i_ip;
      pending_slot  <= i_slot;
      last          <= i_last;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/arp_cache_with_request_retry.sv
// Top level: address cache with aging and pending-request retry.
// Requests are handled one at a time through a single shared table port. A
// lookup scans the cache, a queue request the pending slots, an insert both
// tables, and a tick ages every entry, then walks the pending slots one per
// cycle while the output is not stalled, with one empty result when no
// request is pending. Each result leaves through an output register after it
// is built; a stalled output holds the pending walk and the input.
// Configuration is to be written through cfg_valid/cfg_ready while the block
// is idle (the user is bound; the block itself does not enforce it), index 0
// timeout, index 1 retry limit.
`default_nettype none
module arp_cache_with_request_retry
  import acrr_pkg::*;
#(
  parameter int CACHE_ENTRIES   = 32,
  parameter int PENDING_ENTRIES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  req_type,
  input  wire logic [31:0] ip,
  input  wire logic [47:0] mac,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             hit,
  output logic [47:0]      mac_out,
  output logic             pending_found,
  output logic [1:0]       action,
  output logic [31:0]      action_ip,
  output logic [3:0]       pending_slot,
  output logic             last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data
);

  localparam int CW = $clog2(CACHE_ENTRIES);
  localparam int PW = $clog2(PENDING_ENTRIES);

  logic [7:0] entry_timeout;
  logic [3:0] retry_limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_timeout <= 8'd15;
      retry_limit   <= 4'd5;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TIMEOUT: entry_timeout <= cfg_data;
        CFG_RETRY:   retry_limit   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  acrr_cmd_t     cmd;
  acrr_sts_t     sts;
  logic [CW-1:0] cidx;
  logic [PW-1:0] pidx;
  logic          r_valid, r_stall;
  logic          r_hit, r_pf, r_last;
  logic [47:0]   r_mac;
  logic [1:0]    r_act;
  logic [31:0]   r_ip;
  logic [3:0]    r_slot;

  acrr_ctrl #(.CACHE_ENTRIES(CACHE_ENTRIES), .PENDING_ENTRIES(PENDING_ENTRIES)) u_ctrl (
    .clk, .rst, .in_valid, .req_type, .in_stall,
    .out_valid(r_valid), .out_stall(r_stall), .sts, .cmd, .cidx, .pidx
  );

  acrr_datapath #(.CACHE_ENTRIES(CACHE_ENTRIES), .PENDING_ENTRIES(PENDING_ENTRIES)) u_dp (
    .clk, .rst, .cmd, .cidx, .pidx, .req_type, .ip, .mac,
    .entry_timeout, .retry_limit, .sts,
    .hit(r_hit), .mac_out(r_mac), .pending_found(r_pf), .action(r_act),
    .action_ip(r_ip), .pending_slot(r_slot), .last(r_last)
  );

  acrr_hold u_hold (
    .clk, .rst, .in_valid(r_valid), .in_stall(r_stall),
    .i_mac(r_mac), .i_hit(r_hit), .i_pf(r_pf), .i_act(r_act), .i_ip(r_ip),
    .i_slot(r_slot), .i_last(r_last),
    .out_valid, .out_stall, .hit, .mac_out, .pending_found, .action,
    .action_ip, .pending_slot, .last
  );

`ifndef SYNTH
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config port not ready");
  a_hit_lookup: assert property (@(posedge clk) disable iff (rst)
    (out_valid && hit) |-> (action == ACT_NONE && !pending_found))
    else $error("hit with other result fields");
  a_pf_insert: assert property (@(posedge clk) disable iff (rst)
    (out_valid && pending_found) |-> (!hit && mac_out == 48'd0))
    else $error("pending_found with lookup fields");
`endif

endmodule
`default_nettype wire
